### rtl/core/expression_tokenizer_assert.svh
// Assertion macros for the expression tokenizer.
`ifndef EXPRESSION_TOKENIZER_ASSERT_SVH
`define EXPRESSION_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define ET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/extok_pkg.sv
// Shared types and constants of the expression tokenizer.
`timescale 1ns / 1ps

package extok_pkg;

    localparam int MAX_RES = 7;
    localparam int CNT_W   = 3;

    localparam logic [2:0] EV_START = 3'd0;
    localparam logic [2:0] EV_VALUE = 3'd1;
    localparam logic [2:0] EV_END   = 3'd2;
    localparam logic [2:0] EV_UNTERM = 3'd3;
    localparam logic [2:0] EV_EXPR_END = 3'd4;

    localparam logic [3:0] TK_STR = 4'd0;
    localparam logic [3:0] TK_RE  = 4'd1;
    localparam logic [3:0] TK_LP  = 4'd2;
    localparam logic [3:0] TK_RP  = 4'd3;
    localparam logic [3:0] TK_EQ  = 4'd4;
    localparam logic [3:0] TK_NE  = 4'd5;
    localparam logic [3:0] TK_NOT = 4'd6;
    localparam logic [3:0] TK_AND = 4'd7;
    localparam logic [3:0] TK_OR  = 4'd8;
    localparam logic [3:0] TK_GT  = 4'd9;
    localparam logic [3:0] TK_GE  = 4'd10;
    localparam logic [3:0] TK_LT  = 4'd11;
    localparam logic [3:0] TK_LE  = 4'd12;
    localparam logic [3:0] TK_ACC = 4'd13;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQUAL  = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_PIPE   = 8'h7c;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_STRDBL,
        MODE_QSTR,
        MODE_REGEX,
        MODE_OP,
        MODE_DBL,
        MODE_DASH,
        MODE_DASHL
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] held;
        logic       prev_acc;
        logic       esc;
        logic       swallow;
    } lex_state_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] token_type;
        logic [7:0] value_char;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [2:0] ev;
        logic [3:0] ty;
        logic [7:0] ch;
    } event_t;

    typedef struct packed {
        event_t [MAX_RES-1:0] items;
        logic [CNT_W-1:0]     cnt;
    } bundle_t;

endpackage

### rtl/core/extok_lexer.sv
// Combinational lexer step: one character in, next state and event bundle out.
`timescale 1ns / 1ps

module extok_lexer
    import extok_pkg::*;
(
    input  in_item_t   in_data,
    input  lex_state_t st_cur,
    output lex_state_t st_next,
    output bundle_t    bnd
);

    typedef struct packed {
        lex_state_t st;
        bundle_t    b;
    } lex_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    function automatic lex_t push(lex_t x, logic [2:0] e, logic [3:0] t, logic [7:0] ch);
        if (x.b.cnt < CNT_W'(MAX_RES)) begin
            x.b.items[x.b.cnt] = '{ev: e, ty: t, ch: ch};
            x.b.cnt = x.b.cnt + CNT_W'(1);
        end
        return x;
    endfunction

    function automatic lex_t tok_start(lex_t x, logic [3:0] t);
        x = push(x, EV_START, t, CH_NUL);
        x.st.prev_acc = 1'b0;
        return x;
    endfunction

    function automatic lex_t op_token(lex_t x, logic [3:0] t);
        x = tok_start(x, t);
        x = push(x, EV_END, t, CH_NUL);
        return x;
    endfunction

    function automatic logic [3:0] op_type(logic [7:0] h, logic with_eq);
        logic [3:0] t;
        case (h)
            CH_BANG: t = with_eq ? TK_NE : TK_NOT;
            CH_LT:   t = with_eq ? TK_LE : TK_LT;
            default: t = with_eq ? TK_GE : TK_GT;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] dbl_type(logic [7:0] h);
        return (h == CH_PIPE) ? TK_OR : TK_AND;
    endfunction

    function automatic lex_t idle_char(lex_t x, logic [7:0] c);
        if (!is_ws(c)) begin
            case (c)
                CH_LPAREN: x = op_token(x, TK_LP);
                CH_RPAREN: x = op_token(x, TK_RP);
                CH_EQUAL: begin
                    x = op_token(x, TK_EQ);
                    x.st.swallow = 1'b1;
                end
                CH_BANG, CH_LT, CH_GT: begin
                    x.st.held = c;
                    x.st.mode = MODE_OP;
                end
                CH_QUOTE: begin
                    x = tok_start(x, TK_STR);
                    x.st.mode = MODE_QSTR;
                end
                CH_SLASH: begin
                    if (x.st.prev_acc) begin
                        x = tok_start(x, TK_STR);
                        x = push(x, EV_VALUE, TK_STR, c);
                        x.st.mode = MODE_STR;
                    end else begin
                        x = tok_start(x, TK_RE);
                        x.st.mode = MODE_REGEX;
                    end
                end
                CH_PIPE, CH_AMP: begin
                    x.st.held = c;
                    x.st.mode = MODE_DBL;
                end
                CH_DASH: x.st.mode = MODE_DASH;
                CH_BSLASH: begin
                    x = tok_start(x, TK_STR);
                    x.st.esc = 1'b1;
                    x.st.mode = MODE_STR;
                end
                default: begin
                    x = tok_start(x, TK_STR);
                    x = push(x, EV_VALUE, TK_STR, c);
                    x.st.mode = MODE_STR;
                end
            endcase
        end
        return x;
    endfunction

    function automatic lex_t str_char(lex_t x, logic [7:0] c);
        if (x.st.esc) begin
            x = push(x, EV_VALUE, TK_STR, c);
            x.st.esc = 1'b0;
        end else if (is_ws(c)) begin
            x = push(x, EV_END, TK_STR, CH_NUL);
            x.st.mode = MODE_IDLE;
        end else begin
            case (c)
                CH_LPAREN, CH_RPAREN, CH_EQUAL, CH_BANG, CH_LT, CH_GT: begin
                    x = push(x, EV_END, TK_STR, CH_NUL);
                    x.st.mode = MODE_IDLE;
                    x = idle_char(x, c);
                end
                CH_PIPE, CH_AMP: begin
                    x.st.held = c;
                    x.st.mode = MODE_STRDBL;
                end
                CH_BSLASH: x.st.esc = 1'b1;
                default:   x = push(x, EV_VALUE, TK_STR, c);
            endcase
        end
        return x;
    endfunction

    function automatic lex_t quote_char(lex_t x, logic [7:0] c, logic [7:0] closer,
                                        logic [3:0] t);
        if (x.st.esc) begin
            x = push(x, EV_VALUE, t, c);
            x.st.esc = 1'b0;
        end else if (c == CH_BSLASH) begin
            x.st.esc = 1'b1;
        end else if (c == closer) begin
            x = push(x, EV_END, t, CH_NUL);
            x.st.mode = MODE_IDLE;
        end else begin
            x = push(x, EV_VALUE, t, c);
        end
        return x;
    endfunction

    function automatic lex_t dispatch(lex_t x, logic [7:0] c);
        logic [7:0] h;
        h = x.st.held;
        case (x.st.mode)
            MODE_STR: x = str_char(x, c);
            MODE_STRDBL: begin
                x.st.held = CH_NUL;
                if (c == h) begin
                    x = push(x, EV_END, TK_STR, CH_NUL);
                    x = op_token(x, dbl_type(h));
                    x.st.mode = MODE_IDLE;
                end else begin
                    x = push(x, EV_VALUE, TK_STR, h);
                    x.st.mode = MODE_STR;
                    x = str_char(x, c);
                end
            end
            MODE_QSTR:  x = quote_char(x, c, CH_QUOTE, TK_STR);
            MODE_REGEX: x = quote_char(x, c, CH_SLASH, TK_RE);
            MODE_OP: begin
                x.st.held = CH_NUL;
                x.st.mode = MODE_IDLE;
                if (c == CH_EQUAL) begin
                    x = op_token(x, op_type(h, 1'b1));
                end else begin
                    x = op_token(x, op_type(h, 1'b0));
                    x = idle_char(x, c);
                end
            end
            MODE_DBL: begin
                x.st.held = CH_NUL;
                if (c == h) begin
                    x = op_token(x, dbl_type(h));
                    x.st.mode = MODE_IDLE;
                end else begin
                    x = tok_start(x, TK_STR);
                    x = push(x, EV_VALUE, TK_STR, h);
                    x.st.mode = MODE_STR;
                    x = str_char(x, c);
                end
            end
            MODE_DASH: begin
                if (is_alnum(c)) begin
                    x.st.held = c;
                    x.st.mode = MODE_DASHL;
                end else begin
                    x = tok_start(x, TK_STR);
                    x = push(x, EV_VALUE, TK_STR, CH_DASH);
                    x.st.mode = MODE_STR;
                    x = str_char(x, c);
                end
            end
            MODE_DASHL: begin
                x.st.held = CH_NUL;
                if (is_ws(c)) begin
                    x = push(x, EV_START, TK_ACC, h);
                    x = push(x, EV_END, TK_ACC, h);
                    x.st.prev_acc = 1'b1;
                    x.st.mode = MODE_IDLE;
                end else begin
                    x = tok_start(x, TK_STR);
                    x = push(x, EV_VALUE, TK_STR, CH_DASH);
                    x = push(x, EV_VALUE, TK_STR, h);
                    x.st.mode = MODE_STR;
                    x = str_char(x, c);
                end
            end
            default: begin
                x.st.mode = MODE_IDLE;
                x = idle_char(x, c);
            end
        endcase
        return x;
    endfunction

    function automatic lex_t flush(lex_t x);
        logic [7:0] h;
        h = x.st.held;
        case (x.st.mode)
            MODE_STR: begin
                if (x.st.esc) begin
                    x = push(x, EV_VALUE, TK_STR, CH_BSLASH);
                end
                x = push(x, EV_END, TK_STR, CH_NUL);
            end
            MODE_STRDBL: begin
                x = push(x, EV_VALUE, TK_STR, h);
                x = push(x, EV_END, TK_STR, CH_NUL);
            end
            MODE_QSTR:  x = push(x, EV_UNTERM, TK_STR, CH_NUL);
            MODE_REGEX: x = push(x, EV_UNTERM, TK_RE, CH_NUL);
            MODE_OP:    x = op_token(x, op_type(h, 1'b0));
            MODE_DBL: begin
                x = tok_start(x, TK_STR);
                x = push(x, EV_VALUE, TK_STR, h);
                x = push(x, EV_END, TK_STR, CH_NUL);
            end
            MODE_DASH: begin
                x = tok_start(x, TK_STR);
                x = push(x, EV_VALUE, TK_STR, CH_DASH);
                x = push(x, EV_END, TK_STR, CH_NUL);
            end
            MODE_DASHL: begin
                x = tok_start(x, TK_STR);
                x = push(x, EV_VALUE, TK_STR, CH_DASH);
                x = push(x, EV_VALUE, TK_STR, h);
                x = push(x, EV_END, TK_STR, CH_NUL);
            end
            default: begin
                x.st.mode = MODE_IDLE;
            end
        endcase
        x = push(x, EV_EXPR_END, TK_STR, CH_NUL);
        x.st = '{mode: MODE_IDLE, held: CH_NUL, prev_acc: 1'b0, esc: 1'b0, swallow: 1'b0};
        return x;
    endfunction

    lex_t step;

    always_comb begin
        step.st = st_cur;
        step.b  = '0;
        if (in_data.char_in == CH_NUL) begin
            step = flush(step);
        end else begin
            if (step.st.swallow) begin
                step.st.swallow = 1'b0;
                if (in_data.char_in != CH_EQUAL) begin
                    step = dispatch(step, in_data.char_in);
                end
            end else begin
                step = dispatch(step, in_data.char_in);
            end
            if (in_data.end_of_expr) begin
                step = flush(step);
            end
        end
    end

    assign st_next = step.st;
    assign bnd     = step.b;

endmodule

### rtl/core/expression_tokenizer.sv
// Expression tokenizer top level: input register, lexer step, event bundle drain.
// A character is registered on accept; its events load into the bundle register once the bundle
// is empty or its last event is taken. One character per cycle while each yields at most one
// event and m_ready is high; one yielding more holds the bundle register and the input until
// its last event is taken. Characters with no event leave nothing in the bundle register.
// Reset: synchronous, active low; clears lexer state and all valid flags.
`timescale 1ns / 1ps
`include "expression_tokenizer_assert.svh"

module expression_tokenizer
    import extok_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    in_item_t         in_reg;
    logic             in_vld_reg;
    lex_state_t       st_reg;
    lex_state_t       st_next;
    bundle_t          bnd_reg;
    bundle_t          bnd_next;
    logic             out_vld_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             last_ev;
    logic             load;
    event_t           cur_ev;

    extok_lexer u_lexer (
        .in_data (in_reg),
        .st_cur  (st_reg),
        .st_next (st_next),
        .bnd     (bnd_next)
    );

    assign cur_ev  = bnd_reg.items[idx_reg];
    assign last_ev = (idx_reg == bnd_reg.cnt - CNT_W'(1));
    assign load    = in_vld_reg && (!out_vld_reg || (m_ready && last_ev));
    assign s_ready = !in_vld_reg || load;

    assign m_valid = out_vld_reg;
    assign m_data  = '{event_res: cur_ev.ev, token_type: cur_ev.ty,
                       value_char: cur_ev.ch, last: last_ev};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            idx_reg     <= '0;
            st_reg      <= '{mode: MODE_IDLE, held: CH_NUL, prev_acc: 1'b0,
                             esc: 1'b0, swallow: 1'b0};
        end else begin
            if (s_valid && s_ready) begin
                in_reg     <= s_data;
                in_vld_reg <= 1'b1;
            end else if (load) begin
                in_vld_reg <= 1'b0;
            end
            if (load) begin
                st_reg      <= st_next;
                bnd_reg     <= bnd_next;
                out_vld_reg <= (bnd_next.cnt != '0);
                idx_reg     <= '0;
            end else if (out_vld_reg && m_ready) begin
                if (last_ev) begin
                    out_vld_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
        end
    end

    `ET_ASSERT_NOW(a_idx_in_range, out_vld_reg, idx_reg < bnd_reg.cnt, "event index past bundle")
    `ET_ASSERT_NEXT(a_load_offers, load && |bnd_next.cnt, m_valid && idx_reg == '0, "no offer")
    `ET_ASSERT_NEXT(a_bundle_drains, m_valid && m_ready && !m_data.last, m_valid, "early drop")
    `ET_ASSERT_NEXT(a_accept_held, s_valid && s_ready, in_vld_reg, "accepted character not held")

endmodule
